// ===== sv/pit_pkg.sv =====
// Package for the point-in-tetrahedron classifier: field widths, codes,
// face table and the micro-op table of the shared multiply-accumulate sequence.
// No dependencies.
`default_nettype none

package pit_pkg;

	localparam int FIELD_W = 16;
	localparam int KIND_W  = 3;
	localparam int REL_W   = 2;
	localparam int TOL_W   = 53;
	localparam int APB_DW  = 64;
	localparam int APB_AW  = 3;
	localparam int N_VERT  = 4;
	localparam int STEP_W  = 5;

	localparam logic [APB_AW-1:0] TOL_ADDR   = '0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;
	localparam logic [1:0]        FACE_LAST  = 2'd3;

	localparam logic [STEP_W-1:0] FETCH_Q0    = 5'd1;
	localparam logic [STEP_W-1:0] FETCH_Q1    = 5'd2;
	localparam logic [STEP_W-1:0] FETCH_Q2    = 5'd3;
	localparam logic [STEP_W-1:0] FETCH_OPP   = 5'd4;
	localparam logic [STEP_W-1:0] FETCH_LAST  = 5'd4;
	localparam logic [STEP_W-1:0] CALC_VSTORE = 5'd18;
	localparam logic [STEP_W-1:0] CALC_LAST   = 5'd19;

	typedef enum logic [1:0] {
		REL_INSIDE,
		REL_SURFACE,
		REL_OUTSIDE
	} relation_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_CALC,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		A_E1X,
		A_E1Y,
		A_E1Z,
		A_N0,
		A_N1,
		A_N2
	} a_sel_t;

	typedef enum logic [3:0] {
		B_E2X,
		B_E2Y,
		B_E2Z,
		B_TOX,
		B_TOY,
		B_TOZ,
		B_TPX,
		B_TPY,
		B_TPZ
	} b_sel_t;

	typedef enum logic [1:0] {
		CH_FULL,
		CH_HI,
		CH_LO
	} chunk_t;

	typedef enum logic [1:0] {
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		ST_NONE,
		ST_N0,
		ST_N1,
		ST_N2,
		ST_ORIENT,
		ST_VALUE
	} store_t;

	typedef struct packed {
		logic    valid;
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		chunk_t  chunk;
		acc_op_t acc_op;
		logic    flip_en;
		store_t  store;
	} uop_t;

	typedef struct packed {
		logic    valid;
		logic    shift;
		acc_op_t acc_op;
		logic    flip_en;
		store_t  store;
	} mac_ctl_t;

	// faces (a,b,c|d) (a,c,d|b) (a,b,d|c) (b,c,d|a); slot 3 is the opposite vertex
	function automatic logic [1:0] face_vertex(input logic [1:0] face, input logic [1:0] slot);
		logic [1:0] v;
		case ({face, slot})
			4'h0: v = 2'd0;
			4'h1: v = 2'd1;
			4'h2: v = 2'd2;
			4'h3: v = 2'd3;
			4'h4: v = 2'd0;
			4'h5: v = 2'd2;
			4'h6: v = 2'd3;
			4'h7: v = 2'd1;
			4'h8: v = 2'd0;
			4'h9: v = 2'd1;
			4'hA: v = 2'd3;
			4'hB: v = 2'd2;
			4'hC: v = 2'd1;
			4'hD: v = 2'd2;
			4'hE: v = 2'd3;
			default: v = 2'd0;
		endcase
		return v;
	endfunction

	function automatic uop_t mk_uop(input a_sel_t a, input b_sel_t b, input chunk_t ch,
			input acc_op_t op, input logic flip, input store_t st);
		uop_t u;
		u.valid   = 1'b1;
		u.a_sel   = a;
		u.b_sel   = b;
		u.chunk   = ch;
		u.acc_op  = op;
		u.flip_en = flip;
		u.store   = st;
		return u;
	endfunction

	// cross product, orientation dot, point dot; normals enter as hi/lo halves
	function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			5'd0:  u = mk_uop(A_E1Y, B_E2Z, CH_FULL, ACC_LOAD, 1'b0, ST_NONE);
			5'd1:  u = mk_uop(A_E1Z, B_E2Y, CH_FULL, ACC_SUB,  1'b0, ST_N0);
			5'd2:  u = mk_uop(A_E1Z, B_E2X, CH_FULL, ACC_LOAD, 1'b0, ST_NONE);
			5'd3:  u = mk_uop(A_E1X, B_E2Z, CH_FULL, ACC_SUB,  1'b0, ST_N1);
			5'd4:  u = mk_uop(A_E1X, B_E2Y, CH_FULL, ACC_LOAD, 1'b0, ST_NONE);
			5'd5:  u = mk_uop(A_E1Y, B_E2X, CH_FULL, ACC_SUB,  1'b0, ST_N2);
			5'd6:  u = mk_uop(A_N0,  B_TOX, CH_HI,   ACC_LOAD, 1'b0, ST_NONE);
			5'd7:  u = mk_uop(A_N0,  B_TOX, CH_LO,   ACC_ADD,  1'b0, ST_NONE);
			5'd8:  u = mk_uop(A_N1,  B_TOY, CH_HI,   ACC_ADD,  1'b0, ST_NONE);
			5'd9:  u = mk_uop(A_N1,  B_TOY, CH_LO,   ACC_ADD,  1'b0, ST_NONE);
			5'd10: u = mk_uop(A_N2,  B_TOZ, CH_HI,   ACC_ADD,  1'b0, ST_NONE);
			5'd11: u = mk_uop(A_N2,  B_TOZ, CH_LO,   ACC_ADD,  1'b0, ST_ORIENT);
			5'd12: u = mk_uop(A_N0,  B_TPX, CH_HI,   ACC_LOAD, 1'b1, ST_NONE);
			5'd13: u = mk_uop(A_N0,  B_TPX, CH_LO,   ACC_ADD,  1'b1, ST_NONE);
			5'd14: u = mk_uop(A_N1,  B_TPY, CH_HI,   ACC_ADD,  1'b1, ST_NONE);
			5'd15: u = mk_uop(A_N1,  B_TPY, CH_LO,   ACC_ADD,  1'b1, ST_NONE);
			5'd16: u = mk_uop(A_N2,  B_TPZ, CH_HI,   ACC_ADD,  1'b1, ST_NONE);
			5'd17: u = mk_uop(A_N2,  B_TPZ, CH_LO,   ACC_ADD,  1'b1, ST_VALUE);
			default: begin
				u = mk_uop(A_E1X, B_E2X, CH_FULL, ACC_LOAD, 1'b0, ST_NONE);
				u.valid = 1'b0;
			end
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

// ===== sv/pit_in_if.sv =====
// Input channel interface: valid/ready handshake carrying kind and coordinates.
// Depends on pit_pkg.
`default_nettype none

interface pit_in_if;
	logic                               valid;
	logic                               ready;
	logic [pit_pkg::KIND_W-1:0]         kind;
	logic signed [pit_pkg::FIELD_W-1:0] coord_x;
	logic signed [pit_pkg::FIELD_W-1:0] coord_y;
	logic signed [pit_pkg::FIELD_W-1:0] coord_z;

	modport source (output valid, kind, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, kind, coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

// ===== sv/pit_out_if.sv =====
// Result channel interface: valid/ready handshake carrying the relation code.
// Depends on pit_pkg.
`default_nettype none

interface pit_out_if;
	logic                      valid;
	logic                      ready;
	logic [pit_pkg::REL_W-1:0] relation;

	modport source (output valid, relation, input ready);
	modport sink (input valid, relation, output ready);
endinterface

`default_nettype wire

// ===== sv/pit_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pit_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/pit_mac.sv =====
// Shared multiply-accumulate unit: registered signed product, then a wide
// accumulator with optional shift of the high half and orientation flip.
// Depends on pit_pkg.
`default_nettype none

module pit_mac #(
	parameter int A_W   = 18,
	parameter int B_W   = 17,
	parameter int SHIFT = 17,
	parameter int ACC_W = 55
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire pit_pkg::mac_ctl_t       ctl,
	input  wire logic signed [A_W-1:0]   op_a,
	input  wire logic signed [B_W-1:0]   op_b,
	output logic signed [ACC_W-1:0]      acc_res,
	output pit_pkg::store_t              store
);

	pit_pkg::mac_ctl_t         ctl_s1;
	logic signed [A_W+B_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      flip_q;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [ACC_W-1:0]   term;
	logic signed [ACC_W-1:0]   base;
	logic                      neg;
	logic signed [ACC_W-1:0]   acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_comb begin
		prod_ext = ACC_W'(prod_s1);
		term     = ctl_s1.shift ? (prod_ext <<< SHIFT) : prod_ext;
		base     = (ctl_s1.acc_op == pit_pkg::ACC_LOAD) ? '0 : acc_q;
		neg      = (ctl_s1.acc_op == pit_pkg::ACC_SUB) ^ (ctl_s1.flip_en && flip_q);
		acc_d    = neg ? (base - term) : (base + term);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
		end else if (ctl_s1.valid && (ctl_s1.store == pit_pkg::ST_ORIENT)) begin
			flip_q <= !acc_d[ACC_W-1] && (|acc_d);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			acc_q <= acc_d;
		end
	end

	assign acc_res = acc_d;
	assign store   = ctl_s1.valid ? ctl_s1.store : pit_pkg::ST_NONE;

endmodule

`default_nettype wire

// ===== sv/point_in_tetrahedron_test_core.sv =====
// Top level of the point-in-tetrahedron classifier: APB register, vertex RAM,
// sequencer and face-verdict logic. Depends on pit_pkg, pit_in_if, pit_out_if,
// pit_ram and pit_mac.
//
//   channel   dir  handshake            payload
//   in_ch     in   valid/ready          kind, coord_x, coord_y, coord_z
//   out_ch    out  valid/ready          relation
//   apb       in   psel/penable, pready paddr, pwdata, prdata (surface_tolerance at 0)
//
// A vertex load or an unused kind is taken without leaving IDLE; loads may stream every cycle.
// A query visits four faces; per face the sequencer reads the vertex RAM in FETCH
// and then runs CALC through the one shared multiplier (18 multiplies plus drain).
// in_ch.ready is low while a query is in work; the result register holds one
// verdict, and a finished query waits in DONE while the previous one is untaken.
// Reset clears control state only; the vertex RAM needs no clearing pass.
`default_nettype none

module point_in_tetrahedron_test_core #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	pit_in_if.sink                           in_ch,
	pit_out_if.source                        out_ch,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pit_pkg::APB_AW-1:0]  paddr,
	input  wire logic [pit_pkg::APB_DW-1:0]  pwdata,
	output logic      [pit_pkg::APB_DW-1:0]  prdata,
	output logic                             pready
);

	localparam int CW    = COORD_WIDTH;
	localparam int DW    = CW + 1;
	localparam int NW    = 2 * CW + 2;
	localparam int LO_W  = CW + 1;
	localparam int HI_W  = NW - LO_W;
	localparam int A_W   = CW + 2;
	localparam int B_W   = DW;
	localparam int ACC_W = (3 * CW + 4 > pit_pkg::TOL_W + 2) ? 3 * CW + 4 : pit_pkg::TOL_W + 2;
	localparam int VW    = 3 * CW;
	localparam int FW    = pit_pkg::FIELD_W;

	pit_pkg::state_t              state_q;
	pit_pkg::state_t              state_d;
	logic [pit_pkg::STEP_W-1:0]   step_q;
	logic [1:0]                   face_q;

	logic [pit_pkg::TOL_W-1:0]    tol_q;

	logic                         in_acc;
	logic                         in_ready;
	logic                         is_query;
	logic [FW+CW-1:0]             cx_ext;
	logic [FW+CW-1:0]             cy_ext;
	logic [FW+CW-1:0]             cz_ext;
	logic signed [CW-1:0]         cin [3];

	logic [1:0]                   ram_raddr;
	logic [VW-1:0]                ram_rdata;
	logic signed [CW-1:0]         rd_c [3];

	logic signed [CW-1:0]         p_q [3];
	logic signed [CW-1:0]         q0_q [3];
	logic signed [DW-1:0]         e1_q [3];
	logic signed [DW-1:0]         e2_q [3];
	logic signed [DW-1:0]         to_q [3];
	logic signed [DW-1:0]         tp_q [3];
	logic signed [NW-1:0]         n_q [3];
	logic signed [ACC_W-1:0]      v_q;

	pit_pkg::uop_t                uop;
	pit_pkg::mac_ctl_t            ctl;
	logic signed [A_W-1:0]        op_a;
	logic signed [B_W-1:0]        op_b;
	logic signed [DW-1:0]         ea;
	logic signed [NW-1:0]         nsel;
	logic signed [HI_W-1:0]       n_hi;
	logic [LO_W-1:0]              n_lo;
	logic signed [ACC_W-1:0]      acc_res;
	pit_pkg::store_t              mac_store;

	logic signed [ACC_W-1:0]      tol_ext;
	logic signed [ACC_W:0]        v_plus_tol;
	logic                         v_gt0;
	logic                         v_ge_ntol;
	logic                         v_le_tol;
	logic                         all_pos_q;
	logic                         all_ge_q;
	logic                         any_small_q;
	pit_pkg::relation_t           verdict;

	logic                         out_valid_q;
	pit_pkg::relation_t           rel_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == pit_pkg::TOL_ADDR) ? pit_pkg::APB_DW'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == pit_pkg::TOL_ADDR)) begin
			tol_q <= pwdata[pit_pkg::TOL_W-1:0];
		end
	end

	// input decode
	assign in_acc   = in_ch.valid && in_ready;
	assign is_query = (in_ch.kind == pit_pkg::KIND_QUERY);
	assign cx_ext   = {{CW{1'b0}}, in_ch.coord_x};
	assign cy_ext   = {{CW{1'b0}}, in_ch.coord_y};
	assign cz_ext   = {{CW{1'b0}}, in_ch.coord_z};
	assign cin[0]   = cx_ext[CW-1:0];
	assign cin[1]   = cy_ext[CW-1:0];
	assign cin[2]   = cz_ext[CW-1:0];
	assign in_ch.ready = in_ready;

	pit_ram #(
		.WIDTH(VW),
		.DEPTH(pit_pkg::N_VERT)
	) u_vert_ram (
		.clk   (clk),
		.we    (in_acc && (in_ch.kind < pit_pkg::KIND_QUERY)),
		.waddr (in_ch.kind[1:0]),
		.wdata ({cin[0], cin[1], cin[2]}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_c[0] = ram_rdata[VW-1:2*CW];
	assign rd_c[1] = ram_rdata[2*CW-1:CW];
	assign rd_c[2] = ram_rdata[CW-1:0];

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			pit_pkg::S_IDLE: begin
				if (in_acc && is_query) begin
					state_d = pit_pkg::S_FETCH;
				end
			end
			pit_pkg::S_FETCH: begin
				if (step_q == pit_pkg::FETCH_LAST) begin
					state_d = pit_pkg::S_CALC;
				end
			end
			pit_pkg::S_CALC: begin
				if (step_q == pit_pkg::CALC_LAST) begin
					state_d = (face_q == pit_pkg::FACE_LAST) ? pit_pkg::S_DONE : pit_pkg::S_FETCH;
				end
			end
			pit_pkg::S_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					state_d = pit_pkg::S_IDLE;
				end
			end
			default: state_d = pit_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		ram_raddr = pit_pkg::face_vertex(face_q, step_q[1:0]);
		uop       = pit_pkg::uop_at(step_q);
		ctl       = '0;
		case (state_q)
			pit_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			pit_pkg::S_CALC: begin
				ctl.valid   = uop.valid;
				ctl.shift   = (uop.chunk == pit_pkg::CH_HI);
				ctl.acc_op  = uop.acc_op;
				ctl.flip_en = uop.flip_en;
				ctl.store   = uop.store;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pit_pkg::S_IDLE;
			step_q  <= '0;
			face_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				step_q <= '0;
			end else if ((state_q == pit_pkg::S_FETCH) || (state_q == pit_pkg::S_CALC)) begin
				step_q <= step_q + 1'b1;
			end
			if (state_q == pit_pkg::S_IDLE) begin
				face_q <= '0;
			end else if ((state_q == pit_pkg::S_CALC) && (state_d == pit_pkg::S_FETCH)) begin
				face_q <= face_q + 1'b1;
			end
		end
	end

	// query point and face vectors
	always_ff @(posedge clk) begin
		if (in_acc && is_query) begin
			for (int i = 0; i < 3; i++) begin
				p_q[i] <= cin[i];
			end
		end
		if (state_q == pit_pkg::S_FETCH) begin
			case (step_q)
				pit_pkg::FETCH_Q0: begin
					for (int i = 0; i < 3; i++) begin
						q0_q[i] <= rd_c[i];
						tp_q[i] <= DW'(p_q[i]) - DW'(rd_c[i]);
					end
				end
				pit_pkg::FETCH_Q1: begin
					for (int i = 0; i < 3; i++) begin
						e1_q[i] <= DW'(q0_q[i]) - DW'(rd_c[i]);
					end
				end
				pit_pkg::FETCH_Q2: begin
					for (int i = 0; i < 3; i++) begin
						e2_q[i] <= DW'(q0_q[i]) - DW'(rd_c[i]);
					end
				end
				pit_pkg::FETCH_OPP: begin
					for (int i = 0; i < 3; i++) begin
						to_q[i] <= DW'(q0_q[i]) - DW'(rd_c[i]);
					end
				end
				default: begin
				end
			endcase
		end
		case (mac_store)
			pit_pkg::ST_N0:    n_q[0] <= acc_res[NW-1:0];
			pit_pkg::ST_N1:    n_q[1] <= acc_res[NW-1:0];
			pit_pkg::ST_N2:    n_q[2] <= acc_res[NW-1:0];
			pit_pkg::ST_VALUE: v_q <= acc_res;
			default: begin
			end
		endcase
	end

	// operand select
	always_comb begin
		ea   = e1_q[0];
		nsel = n_q[0];
		case (uop.a_sel)
			pit_pkg::A_E1X: ea = e1_q[0];
			pit_pkg::A_E1Y: ea = e1_q[1];
			pit_pkg::A_E1Z: ea = e1_q[2];
			pit_pkg::A_N0:  nsel = n_q[0];
			pit_pkg::A_N1:  nsel = n_q[1];
			pit_pkg::A_N2:  nsel = n_q[2];
			default:        ea = e1_q[0];
		endcase
		n_hi = nsel[NW-1:LO_W];
		n_lo = nsel[LO_W-1:0];
		case (uop.chunk)
			pit_pkg::CH_HI: op_a = A_W'(n_hi);
			pit_pkg::CH_LO: op_a = $signed(A_W'(n_lo));
			default:        op_a = A_W'(ea);
		endcase
		case (uop.b_sel)
			pit_pkg::B_E2X: op_b = e2_q[0];
			pit_pkg::B_E2Y: op_b = e2_q[1];
			pit_pkg::B_E2Z: op_b = e2_q[2];
			pit_pkg::B_TOX: op_b = to_q[0];
			pit_pkg::B_TOY: op_b = to_q[1];
			pit_pkg::B_TOZ: op_b = to_q[2];
			pit_pkg::B_TPX: op_b = tp_q[0];
			pit_pkg::B_TPY: op_b = tp_q[1];
			pit_pkg::B_TPZ: op_b = tp_q[2];
			default:        op_b = e2_q[0];
		endcase
	end

	pit_mac #(
		.A_W   (A_W),
		.B_W   (B_W),
		.SHIFT (LO_W),
		.ACC_W (ACC_W)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.op_a    (op_a),
		.op_b    (op_b),
		.acc_res (acc_res),
		.store   (mac_store)
	);

	// face verdict
	always_comb begin
		tol_ext    = ACC_W'(tol_q);
		v_plus_tol = (ACC_W + 1)'(v_q) + (ACC_W + 1)'(tol_ext);
		v_gt0      = !v_q[ACC_W-1] && (|v_q);
		v_ge_ntol  = !v_plus_tol[ACC_W];
		v_le_tol   = (v_q <= tol_ext);
		if (all_pos_q) begin
			verdict = pit_pkg::REL_INSIDE;
		end else if (all_ge_q && any_small_q) begin
			verdict = pit_pkg::REL_SURFACE;
		end else begin
			verdict = pit_pkg::REL_OUTSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_pos_q   <= 1'b1;
			all_ge_q    <= 1'b1;
			any_small_q <= 1'b0;
		end else if (in_acc && is_query) begin
			all_pos_q   <= 1'b1;
			all_ge_q    <= 1'b1;
			any_small_q <= 1'b0;
		end else if ((state_q == pit_pkg::S_CALC) && (step_q == pit_pkg::CALC_LAST)) begin
			all_pos_q   <= all_pos_q && v_gt0;
			all_ge_q    <= all_ge_q && v_ge_ntol;
			any_small_q <= any_small_q || v_le_tol;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == pit_pkg::S_DONE) && (state_d == pit_pkg::S_IDLE)) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == pit_pkg::S_DONE) && (state_d == pit_pkg::S_IDLE)) begin
			rel_q <= verdict;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.relation = rel_q;

	a_value_step: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_store == pit_pkg::ST_VALUE) |->
			((state_q == pit_pkg::S_CALC) && (step_q == pit_pkg::CALC_VSTORE)))
		else $error("face value stored outside its sequencer step");

	a_done_face: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == pit_pkg::S_CALC) && (state_d == pit_pkg::S_DONE)) |->
			(face_q == pit_pkg::FACE_LAST))
		else $error("query finished before the last face");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_query) |=> ((state_q == pit_pkg::S_FETCH) && (face_q == '0)))
		else $error("accepted query did not start at the first face");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == pit_pkg::S_DONE))
		else $error("result raised without a finished query");

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.valid |-> !in_ch.ready)
		else $error("input ready while the shared multiplier is in use");

endmodule

`default_nettype wire
